// ----- sv/tle_pkg.sv -----
// Shared types, codes and constants of the text line editor with history.
package tle_pkg;

  // Default geometry.
  localparam int unsigned LINE_WIDTH_DEF    = 80;
  localparam int unsigned SCREEN_ROWS_DEF   = 25;
  localparam int unsigned HISTORY_LINES_DEF = 128;

  // Field widths of the stream beats.
  localparam int unsigned OP_W       = 3;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned ROW_W      = 5;
  localparam int unsigned COL_W      = 7;
  localparam int unsigned CELL_W     = 16;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned COLOR_W    = 8;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned IN_USER_W  = OP_W;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned OUT_USER_W = 1;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - CELL_W - 4 * POS_W;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
  localparam logic [OP_W-1:0] OP_LEFT      = 3'd1;
  localparam logic [OP_W-1:0] OP_RIGHT     = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE    = 3'd3;
  localparam logic [OP_W-1:0] OP_BACKSPACE = 3'd4;
  localparam logic [OP_W-1:0] OP_ENTER     = 3'd5;
  localparam logic [OP_W-1:0] OP_READ      = 3'd6;

  // Characters and colors.
  localparam logic [CHAR_W-1:0]  CHAR_CURSOR = 8'h5F;
  localparam logic [CHAR_W-1:0]  CHAR_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0]  CHAR_NUL    = 8'h00;
  localparam logic [COLOR_W-1:0] COLOR_RESET = 8'd7;
  localparam logic [CELL_W-1:0]  RESET_CELL  = {COLOR_RESET, CHAR_NUL};

  // One result beat.
  typedef struct packed {
    logic [POS_W-1:0]  top_row;
    logic [POS_W-1:0]  history_row;
    logic [POS_W-1:0]  line_length;
    logic [POS_W-1:0]  cursor_column;
    logic              cell_written;
    logic [CELL_W-1:0] cell_value;
  } tle_res_t;

endpackage

// ----- sv/tle_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module tle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/tle_out.sv -----
// Output register stage that holds one result beat until the sink takes it.
module tle_out (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  tle_pkg::tle_res_t                   res_i,
  output logic                                free_o,
  output logic                                m_tvalid_o,
  input  logic                                m_tready_i,
  output logic [tle_pkg::OUT_DATA_W-1:0]      m_tdata_o,
  output logic [tle_pkg::OUT_USER_W-1:0]      m_tuser_o
);
  import tle_pkg::*;

  logic     valid_q, valid_d;
  tle_res_t res_q;

  assign free_o = !valid_q || m_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = {{OUT_PAD_W{1'b0}}, res_q.top_row, res_q.history_row,
                       res_q.line_length, res_q.cursor_column, res_q.cell_value};
  assign m_tuser_o  = res_q.cell_written;

endmodule

// ----- sv/text_line_editor_with_history.sv -----
// Steps to a result: a read passes RBASE, RISSUE, RDATA and OUT; cursor moves, no-op edits and
// unused codes go straight to OUT; insert/delete/backspace pass SHIFT, one char per cycle, then OUT;
// enter passes EBASE and ENTER, one history cell per cycle, LINE_WIDTH cells on a row's first write.
// Keys are taken one at a time; a finished beat waits in the output register as the next one starts.
// Reset clears the cursor, length, history row, top row and sets the color to 7; no clearing pass runs.
// History rows not yet written read as NUL in color 7, tracked by the write row and a wrap flag.
module text_line_editor_with_history #(
  parameter int unsigned LINE_WIDTH    = tle_pkg::LINE_WIDTH_DEF,
  parameter int unsigned SCREEN_ROWS   = tle_pkg::SCREEN_ROWS_DEF,
  parameter int unsigned HISTORY_LINES = tle_pkg::HISTORY_LINES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tle_pkg::COLOR_W-1:0]       cfg_data_i,     // text_color
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // key_char [7:0], screen_row [12:8], screen_column [19:13], zero pad
  input  logic [tle_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // operation [2:0]
  input  logic [tle_pkg::IN_USER_W-1:0]     s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // cell_value [15:0], cursor_column [22:16], line_length [29:23],
  // history_row [36:30], first_visible_row [43:37], zero pad
  output logic [tle_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // cell_written [0]
  output logic [tle_pkg::OUT_USER_W-1:0]    m_axis_tuser
);
  import tle_pkg::*;

  localparam int unsigned CW     = $clog2(LINE_WIDTH);
  localparam int unsigned CNTW   = CW + 1;
  localparam int unsigned RW     = (HISTORY_LINES > 1) ? $clog2(HISTORY_LINES) : 1;
  localparam int unsigned LNW    = RW + 6;
  localparam int unsigned TW     = RW + 8;
  localparam int unsigned XW     = CW + 7;
  localparam int unsigned HDEPTH = HISTORY_LINES * LINE_WIDTH;
  localparam int unsigned HA     = $clog2(HDEPTH);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SHIFT  = 3'd1;
  localparam logic [2:0] ST_EBASE  = 3'd2;
  localparam logic [2:0] ST_ENTER  = 3'd3;
  localparam logic [2:0] ST_RBASE  = 3'd4;
  localparam logic [2:0] ST_RISSUE = 3'd5;
  localparam logic [2:0] ST_RDATA  = 3'd6;
  localparam logic [2:0] ST_OUT    = 3'd7;

  // Control state.
  logic [2:0]         state_q, state_d;
  logic [CW-1:0]      cursor_q, cursor_d;
  logic [CW-1:0]      len_q, len_d;
  logic [RW-1:0]      hwr_q, hwr_d;
  logic [RW-1:0]      top_q, top_d;
  logic               wrapped_q, wrapped_d;
  logic [COLOR_W-1:0] color_q, color_d;
  logic [CNTW-1:0]    cnt_q, cnt_d;
  logic               pend_q, pend_d;

  // Item and work registers.
  logic [OP_W-1:0]    op_q, op_d;
  logic [CHAR_W-1:0]  ch_q, ch_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      pend_idx_q, pend_idx_d;
  logic               up_q, up_d;
  logic [HA-1:0]      hbase_q, hbase_d;
  logic               in_range_q, in_range_d;
  logic               hist_ok_q, hist_ok_d;
  logic               filled_q, filled_d;
  logic               edit_row_q, edit_row_d;
  logic [CELL_W-1:0]  cell_value_q, cell_value_d;
  logic               cell_written_q, cell_written_d;

  // Memory ports.
  logic               e_we;
  logic [CW-1:0]      e_waddr, e_raddr;
  logic [CHAR_W-1:0]  e_wdata, e_rdata;
  logic               h_we;
  logic [HA-1:0]      h_waddr, h_raddr;
  logic [CELL_W-1:0]  h_wdata, h_rdata;

  // Helpers.
  logic [OP_W-1:0]    in_op;
  logic [RW-1:0]      hwr_next;
  logic               hwr_wrap;
  logic [TW-1:0]      top_need, top_have;
  logic [LNW-1:0]     line;
  logic [XW-1:0]      col_ext;
  logic               out_free, out_load;
  tle_res_t           res;

  assign in_op       = s_axis_tuser;
  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);

  assign hwr_wrap = (hwr_q == RW'(HISTORY_LINES - 1));
  assign hwr_next = hwr_wrap ? '0 : hwr_q + RW'(1);
  // The top row follows the write row so that the edit row stays on screen.
  assign top_need = TW'(hwr_next) + TW'(1);
  assign top_have = TW'(top_q) + TW'(SCREEN_ROWS);

  assign line    = LNW'(top_q) + LNW'(row_q);
  assign col_ext = XW'(col_q);
  assign h_raddr = hbase_q + HA'(col_q);

  always_comb begin
    state_d        = state_q;
    cursor_d       = cursor_q;
    len_d          = len_q;
    hwr_d          = hwr_q;
    top_d          = top_q;
    wrapped_d      = wrapped_q;
    color_d        = cfg_valid_i ? cfg_data_i : color_q;
    cnt_d          = cnt_q;
    pend_d         = pend_q;
    op_d           = op_q;
    ch_d           = ch_q;
    row_d          = row_q;
    col_d          = col_q;
    idx_d          = idx_q;
    pend_idx_d     = pend_idx_q;
    up_d           = up_q;
    hbase_d        = hbase_q;
    in_range_d     = in_range_q;
    hist_ok_d      = hist_ok_q;
    filled_d       = filled_q;
    edit_row_d     = edit_row_q;
    cell_value_d   = cell_value_q;
    cell_written_d = cell_written_q;
    e_we           = 1'b0;
    e_waddr        = pend_idx_q;
    e_wdata        = e_rdata;
    e_raddr        = idx_q;
    h_we           = 1'b0;
    h_waddr        = hbase_q + HA'(pend_idx_q);
    h_wdata        = RESET_CELL;
    out_load       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_d           = in_op;
          ch_d           = s_axis_tdata[7:0];
          row_d          = s_axis_tdata[12:8];
          col_d          = s_axis_tdata[19:13];
          cell_value_d   = '0;
          cell_written_d = 1'b0;
          pend_d         = 1'b0;
          state_d        = ST_OUT;
          case (in_op)
            OP_INSERT: begin
              if (len_q < CW'(LINE_WIDTH - 1)) begin
                cnt_d   = CNTW'(len_q) - CNTW'(cursor_q);
                idx_d   = len_q - CW'(1);
                up_d    = 1'b0;
                state_d = ST_SHIFT;
              end
            end
            OP_LEFT: begin
              if (cursor_q != '0) begin
                cursor_d = cursor_q - CW'(1);
              end
            end
            OP_RIGHT: begin
              if (cursor_q < len_q) begin
                cursor_d = cursor_q + CW'(1);
              end
            end
            OP_DELETE: begin
              if (cursor_q < len_q) begin
                cnt_d   = CNTW'(len_q) - CNTW'(cursor_q) - CNTW'(1);
                idx_d   = cursor_q + CW'(1);
                up_d    = 1'b1;
                state_d = ST_SHIFT;
              end
            end
            OP_BACKSPACE: begin
              if (cursor_q != '0) begin
                cnt_d   = CNTW'(len_q) - CNTW'(cursor_q);
                idx_d   = cursor_q;
                up_d    = 1'b1;
                state_d = ST_SHIFT;
              end
            end
            OP_ENTER: begin
              if (len_q != '0) begin
                state_d = ST_EBASE;
              end
            end
            OP_READ: begin
              state_d = ST_RBASE;
            end
            default: begin
              state_d = ST_OUT;
            end
          endcase
        end
      end

      // Each move reads one character and writes it next door in the next cycle.
      ST_SHIFT: begin
        if (pend_q) begin
          e_we    = 1'b1;
          e_waddr = pend_idx_q;
          e_wdata = e_rdata;
        end
        if (cnt_q != '0) begin
          e_raddr    = idx_q;
          pend_d     = 1'b1;
          pend_idx_d = up_q ? idx_q - CW'(1) : idx_q + CW'(1);
          idx_d      = up_q ? idx_q + CW'(1) : idx_q - CW'(1);
          cnt_d      = cnt_q - CNTW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            case (op_q)
              OP_INSERT: begin
                e_we     = 1'b1;
                e_waddr  = cursor_q;
                e_wdata  = ch_q;
                cursor_d = cursor_q + CW'(1);
                len_d    = len_q + CW'(1);
              end
              OP_DELETE: begin
                len_d = len_q - CW'(1);
              end
              OP_BACKSPACE: begin
                len_d    = len_q - CW'(1);
                cursor_d = cursor_q - CW'(1);
              end
              default: begin
                len_d = len_q;
              end
            endcase
            state_d = ST_OUT;
          end
        end
      end

      // A row written for the first time is written across its full width.
      ST_EBASE: begin
        hbase_d = HA'(hwr_q) * HA'(LINE_WIDTH);
        idx_d   = '0;
        pend_d  = 1'b0;
        cnt_d   = wrapped_q ? CNTW'(len_q) + CNTW'(1) : CNTW'(LINE_WIDTH);
        state_d = ST_ENTER;
      end

      ST_ENTER: begin
        if (pend_q) begin
          h_we    = 1'b1;
          h_waddr = hbase_q + HA'(pend_idx_q);
          if (pend_idx_q < len_q) begin
            h_wdata = {color_q, e_rdata};
          end else if (pend_idx_q == len_q) begin
            h_wdata = {color_q, CHAR_NUL};
          end else begin
            h_wdata = RESET_CELL;
          end
        end
        if (cnt_q != '0) begin
          e_raddr    = idx_q;
          pend_d     = 1'b1;
          pend_idx_d = idx_q;
          idx_d      = idx_q + CW'(1);
          cnt_d      = cnt_q - CNTW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            hwr_d    = hwr_next;
            len_d    = '0;
            cursor_d = '0;
            if (hwr_wrap) begin
              wrapped_d = 1'b1;
            end
            if (top_need > top_have) begin
              top_d = RW'(top_need - TW'(SCREEN_ROWS));
            end
            state_d = ST_OUT;
          end
        end
      end

      ST_RBASE: begin
        in_range_d = (7'(row_q) < 7'(SCREEN_ROWS)) && (col_ext < XW'(LINE_WIDTH));
        hist_ok_d  = (line < LNW'(HISTORY_LINES));
        filled_d   = wrapped_q || (line < LNW'(hwr_q));
        edit_row_d = (hwr_q >= top_q) && (LNW'(hwr_q - top_q) == LNW'(row_q));
        hbase_d    = HA'(line[RW-1:0]) * HA'(LINE_WIDTH);
        state_d    = ST_RISSUE;
      end

      ST_RISSUE: begin
        e_raddr = col_ext[CW-1:0];
        state_d = ST_RDATA;
      end

      // The edit row is drawn over the history row at the same screen row.
      ST_RDATA: begin
        if (in_range_q) begin
          if (hist_ok_q) begin
            cell_value_d   = filled_q ? h_rdata : RESET_CELL;
            cell_written_d = 1'b1;
          end
          if (edit_row_q) begin
            if (col_ext == XW'(cursor_q)) begin
              cell_value_d = {color_q, CHAR_CURSOR};
            end else if (col_ext < XW'(len_q)) begin
              cell_value_d = {color_q, e_rdata};
            end else begin
              cell_value_d = {color_q, CHAR_SPACE};
            end
            cell_written_d = 1'b1;
          end
        end
        state_d = ST_OUT;
      end

      ST_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cursor_q  <= '0;
      len_q     <= '0;
      hwr_q     <= '0;
      top_q     <= '0;
      wrapped_q <= 1'b0;
      color_q   <= COLOR_RESET;
      cnt_q     <= '0;
      pend_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cursor_q  <= cursor_d;
      len_q     <= len_d;
      hwr_q     <= hwr_d;
      top_q     <= top_d;
      wrapped_q <= wrapped_d;
      color_q   <= color_d;
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q           <= op_d;
    ch_q           <= ch_d;
    row_q          <= row_d;
    col_q          <= col_d;
    idx_q          <= idx_d;
    pend_idx_q     <= pend_idx_d;
    up_q           <= up_d;
    hbase_q        <= hbase_d;
    in_range_q     <= in_range_d;
    hist_ok_q      <= hist_ok_d;
    filled_q       <= filled_d;
    edit_row_q     <= edit_row_d;
    cell_value_q   <= cell_value_d;
    cell_written_q <= cell_written_d;
  end

  assign res.cell_value    = cell_value_q;
  assign res.cell_written  = cell_written_q;
  assign res.cursor_column = POS_W'(cursor_q);
  assign res.line_length   = POS_W'(len_q);
  assign res.history_row   = POS_W'(hwr_q);
  assign res.top_row       = POS_W'(top_q);

  tle_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (LINE_WIDTH)
  ) u_edit_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  tle_ram #(
    .WIDTH (CELL_W),
    .DEPTH (HDEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  tle_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (out_load),
    .res_i      (res),
    .free_o     (out_free),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser)
  );

endmodule

// ----- sim/tb_top.sv -----
// Testbench for the text line editor: key stream driver, result monitor and a line editor model.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tle_pkg::*;

  localparam int unsigned ROW_CELLS    = LINE_WIDTH_DEF;
  localparam int unsigned SCREEN_LINES = SCREEN_ROWS_DEF;
  localparam int unsigned RING_LINES   = HISTORY_LINES_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int unsigned PHASE_ITEMS  = 170;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned REPORT_MAX   = 10;
  localparam int unsigned PAD_W        = IN_DATA_W - CHAR_W - ROW_W - COL_W;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } key_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_val;
    logic              written;
    logic [POS_W-1:0]  cursor;
    logic [POS_W-1:0]  length;
    logic [POS_W-1:0]  hist_row;
    logic [POS_W-1:0]  top_row;
  } editor_view_t;

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   cfg_valid_i    = 1'b0;
  logic [COLOR_W-1:0]     cfg_data_i     = '0;
  logic                   cfg_ready_o;
  logic                   s_axis_tvalid  = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata   = '0;  // key_char, screen_row, screen_column, pad
  logic [IN_USER_W-1:0]   s_axis_tuser   = '0;  // operation
  logic                   m_axis_tvalid;
  logic                   m_axis_tready  = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;   // cell_value, cursor, length, history row, top row, pad
  logic [OUT_USER_W-1:0]  m_axis_tuser;   // cell_written

  // Line editor model state.
  logic [COLOR_W-1:0] text_color;
  logic [CHAR_W-1:0]  edit_chars [ROW_CELLS];
  int unsigned        edit_len;
  int unsigned        edit_cur;
  int unsigned        hist_row;
  int unsigned        top_row;
  logic [CELL_W-1:0]  history_cells [RING_LINES][ROW_CELLS];

  key_item_t    pending_keys[$];
  editor_view_t expected_views[$];
  int unsigned  keys_queued    = 0;
  int unsigned  keys_accepted  = 0;
  int unsigned  results_seen   = 0;
  int unsigned  error_count    = 0;
  int unsigned  idle_cycles    = 0;
  int unsigned  in_gap         = 0;
  int unsigned  out_stall      = 0;
  int unsigned  hold_requests  = 0;
  int unsigned  holds_served   = 0;
  int unsigned  phase_items    = 0;
  bit           steady_flow    = 1'b0;

  text_line_editor_with_history u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [CELL_W-1:0] colored(input logic [CHAR_W-1:0] ch);
    return {text_color, ch};
  endfunction

  function automatic void reset_editor_model();
    text_color = COLOR_RESET;
    foreach (edit_chars[i]) edit_chars[i] = CHAR_NUL;
    edit_len = 0;
    edit_cur = 0;
    hist_row = 0;
    top_row  = 0;
    foreach (history_cells[r, c]) history_cells[r][c] = RESET_CELL;
  endfunction

  function automatic void remove_char(input int unsigned pos);
    for (int unsigned i = pos; i + 1 < edit_len; i++) edit_chars[i] = edit_chars[i + 1];
    edit_len--;
  endfunction

  function automatic void commit_line();
    if (edit_len != 0) begin
      for (int unsigned i = 0; i < edit_len; i++) begin
        history_cells[hist_row][i] = colored(edit_chars[i]);
      end
      history_cells[hist_row][edit_len] = colored(CHAR_NUL);
      hist_row = (hist_row + 1 >= RING_LINES) ? 0 : hist_row + 1;
      foreach (edit_chars[i]) edit_chars[i] = CHAR_NUL;
      edit_len = 0;
      edit_cur = 0;
      // Scroll so that the next history row stays on screen.
      if (hist_row + 1 > top_row + SCREEN_LINES) top_row = hist_row + 1 - SCREEN_LINES;
    end
  endfunction

  // Applies one key to the model and returns the result beat it should produce.
  function automatic editor_view_t next_editor_view(input key_item_t k);
    editor_view_t v;
    int unsigned  ring_line;
    v = '0;
    case (k.op)
      OP_INSERT: begin
        if (edit_len < ROW_CELLS - 1) begin
          for (int unsigned i = edit_len; i > edit_cur; i--) edit_chars[i] = edit_chars[i - 1];
          edit_chars[edit_cur] = k.ch;
          edit_cur++;
          edit_len++;
        end
      end
      OP_LEFT: begin
        if (edit_cur > 0) edit_cur--;
      end
      OP_RIGHT: begin
        if (edit_cur < edit_len) edit_cur++;
      end
      OP_DELETE: begin
        if (edit_cur < edit_len) remove_char(edit_cur);
      end
      OP_BACKSPACE: begin
        if (edit_cur > 0) begin
          remove_char(edit_cur - 1);
          edit_cur--;
        end
      end
      OP_ENTER: begin
        commit_line();
      end
      OP_READ: begin
        if (k.row < SCREEN_LINES && k.col < ROW_CELLS) begin
          ring_line = top_row + k.row;
          if (ring_line < RING_LINES) begin
            v.cell_val = history_cells[ring_line][k.col];
            v.written  = 1'b1;
          end
          // The edit row is drawn over history, and disappears once the row wraps above top.
          if (hist_row >= top_row && hist_row - top_row == k.row) begin
            if (k.col == edit_cur) v.cell_val = colored(CHAR_CURSOR);
            else if (k.col < edit_len) v.cell_val = colored(edit_chars[k.col]);
            else v.cell_val = colored(CHAR_SPACE);
            v.written = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    v.cursor   = 7'(edit_cur);
    v.length   = 7'(edit_len);
    v.hist_row = 7'(hist_row);
    v.top_row  = 7'(top_row);
    return v;
  endfunction

  function automatic string view_text(input editor_view_t v);
    return $sformatf("cell=%h written=%b cursor=%0d length=%0d hist=%0d top=%0d",
                     v.cell_val, v.written, v.cursor, v.length, v.hist_row, v.top_row);
  endfunction

  function automatic void flag_error(input string msg);
    error_count++;
    if (error_count <= REPORT_MAX) $display("%s", msg);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (steady_flow || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(12, 60);
  endfunction

  // Key driver.
  always @(posedge clk_i) begin
    key_item_t k;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (in_gap > 0) begin
        in_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_keys.size() != 0) begin
        k = pending_keys.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{PAD_W{1'b0}}, k.col, k.row, k.ch};
        s_axis_tuser  <= k.op;
        in_gap = pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver, with random stalls and the occasional long hold-off.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (holds_served != hold_requests) begin
        holds_served++;
        out_stall = LONG_HOLD;
      end
      if (out_stall > 0) begin
        out_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        out_stall = pick_gap();
      end
    end
  end

  // Monitor: predicts on every accepted key beat and checks every result beat.
  always @(posedge clk_i) begin
    key_item_t    k;
    editor_view_t seen;
    editor_view_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        k.op  = s_axis_tuser;
        k.ch  = s_axis_tdata[7:0];
        k.row = s_axis_tdata[12:8];
        k.col = s_axis_tdata[19:13];
        expected_views.push_back(next_editor_view(k));
        keys_accepted++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen.cell_val = m_axis_tdata[15:0];
        seen.cursor   = m_axis_tdata[22:16];
        seen.length   = m_axis_tdata[29:23];
        seen.hist_row = m_axis_tdata[36:30];
        seen.top_row  = m_axis_tdata[43:37];
        seen.written  = m_axis_tuser[0];
        if (expected_views.size() == 0) begin
          flag_error($sformatf("unexpected result beat %0d: %s", results_seen, view_text(seen)));
        end else begin
          want = expected_views.pop_front();
          if (seen.cell_val !== want.cell_val || seen.written !== want.written ||
              seen.cursor !== want.cursor || seen.length !== want.length ||
              seen.hist_row !== want.hist_row || seen.top_row !== want.top_row) begin
            flag_error($sformatf("result %0d mismatch: expected %s, got %s",
                                 results_seen, view_text(want), view_text(seen)));
          end
        end
        results_seen++;
      end
    end
  end

  // Watchdog on cycles with no beat accepted anywhere.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_key(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                          input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    key_item_t k;
    k.op  = op;
    k.ch  = ch;
    k.row = row;
    k.col = col;
    pending_keys.push_back(k);
    keys_queued++;
    phase_items++;
  endtask

  // Plain operation with junk in the fields it should ignore.
  task automatic push_op(input logic [OP_W-1:0] op);
    push_key(op, 8'($urandom), 5'($urandom), 7'($urandom));
  endtask

  task automatic push_char(input logic [CHAR_W-1:0] ch);
    push_key(OP_INSERT, ch, 5'($urandom), 7'($urandom));
  endtask

  task automatic push_read(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    push_key(OP_READ, 8'($urandom), row, col);
  endtask

  // Read biased toward the edit row and the written part of lines.
  task automatic push_random_read();
    int unsigned      r;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    r = $urandom_range(99);
    if (r < 40 && hist_row >= top_row) row = 5'(hist_row - top_row);
    else if (r < 85) row = 5'($urandom_range(SCREEN_LINES - 1));
    else row = 5'($urandom_range(31));
    r = $urandom_range(99);
    if (r < 50) col = 7'($urandom_range(edit_len + 1));
    else if (r < 85) col = 7'($urandom_range(ROW_CELLS - 1));
    else col = 7'($urandom_range(127));
    push_read(row, col);
  endtask

  task automatic directed_keys();
    push_read(5'd0, 7'd0);
    push_read(5'd1, 7'd0);
    push_read(5'(SCREEN_LINES - 1), 7'(ROW_CELLS - 1));
    push_read(5'(SCREEN_LINES), 7'd0);
    push_read(5'd0, 7'(ROW_CELLS));
    push_read(5'd31, 7'd127);
    // Edges of an empty line, then an empty enter.
    push_op(OP_LEFT);
    push_op(OP_BACKSPACE);
    push_op(OP_DELETE);
    push_op(OP_RIGHT);
    push_op(OP_ENTER);
    push_char(8'h00);
    push_char(8'hFF);
    push_char(8'h41);
    push_op(OP_LEFT);
    push_op(OP_LEFT);
    push_op(OP_RIGHT);
    push_char(8'h80);
    push_read(5'd0, 7'd2);
    push_read(5'd0, 7'd3);
    push_read(5'd0, 7'd5);
    push_op(OP_DELETE);
    push_op(OP_BACKSPACE);
    push_op(OP_UNUSED);
    push_op(OP_ENTER);
    push_read(5'd0, 7'd1);
    push_read(5'd0, 7'd2);
    push_read(5'd1, 7'd0);
  endtask

  task automatic random_sequence(input bit full_line);
    int unsigned r;
    int unsigned n;
    r = $urandom_range(99);
    if (full_line) begin
      // Two more characters than fit, so the last ones are dropped.
      repeat (ROW_CELLS + 1) push_char(8'($urandom));
      push_read(5'(hist_row - top_row), 7'(ROW_CELLS - 2));
      push_read(5'(hist_row - top_row), 7'(ROW_CELLS - 1));
      push_op(OP_LEFT);
      push_read(5'(hist_row - top_row), 7'(ROW_CELLS - 2));
      push_op(OP_ENTER);
    end else if (r < 62) begin
      n = ($urandom_range(99) < 80) ? 1 : $urandom_range(2, 5);
      repeat (n) push_char(8'($urandom));
      push_op(OP_ENTER);
    end else if (r < 77) begin
      repeat ($urandom_range(1, 4)) push_random_read();
    end else if (r < 92) begin
      repeat ($urandom_range(3, 10)) begin
        case ($urandom_range(9))
          0, 1, 2, 3: push_char(8'($urandom));
          4:          push_op(OP_LEFT);
          5, 9:       push_op(OP_RIGHT);
          6:          push_op(OP_DELETE);
          7:          push_op(OP_BACKSPACE);
          default:    push_random_read();
        endcase
      end
      if ($urandom_range(99) < 60) push_op(OP_ENTER);
    end else begin
      push_key(3'($urandom_range(7)), 8'($urandom), 5'($urandom), 7'($urandom));
    end
  endtask

  // Holds the sender back until every key has been accepted and answered.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (keys_accepted != keys_queued || expected_views.size() != 0);
  endtask

  task automatic write_text_color(input logic [COLOR_W-1:0] color);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= color;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    text_color = color;
  endtask

  initial begin
    int unsigned seq;
    logic [COLOR_W-1:0] color;
    reset_editor_model();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    directed_keys();
    wait_drained();
    for (int p = 0; p < 3; p++) begin
      if (p == 0) color = 8'h00;
      else if (p == 1) color = 8'hFF;
      else color = 8'($urandom_range(1, 254));
      write_text_color(color);
      // Long receiver hold while keys keep coming, so the block backs up.
      if (p == 1) hold_requests++;
      phase_items = 0;
      seq = 0;
      while (phase_items < PHASE_ITEMS) begin
        while (pending_keys.size() > 4) @(posedge clk_i);
        if (seq % 30 == 0) steady_flow = ($urandom_range(99) < 30);
        random_sequence(p == 0 && seq == 15);
        seq++;
      end
      wait_drained();
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/tle_pkg.sv
sv/tle_ram.sv
sv/tle_out.sv
sv/text_line_editor_with_history.sv
sim/tb_top.sv
